@@ src/one_wire_bus_master_core_macros.svh @@
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ONE_WIRE_BUS_MASTER_CORE_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define OWB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define OWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/owb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owb_pkg
// Shared types, command codes, register indexes and the CRC-8 helper of the
// one-wire bus master.
// ---------------------------------------------------------------------------
package owb_pkg;

  // Command codes carried by in_op
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_RESET   = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_CLR_CRC = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [2:0] CFG_PRES_DELAY   = 3'd1;
  localparam logic [2:0] CFG_RESET_TAIL   = 3'd2;
  localparam logic [2:0] CFG_SHORT_LOW    = 3'd3;
  localparam logic [2:0] CFG_LONG_LOW     = 3'd4;
  localparam logic [2:0] CFG_SLOT_LEN     = 3'd5;
  localparam logic [2:0] CFG_READ_SAMPLE  = 3'd6;

  localparam int unsigned CFG_DATA_W = 10;

  // Dallas CRC-8, reflected polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Reset values of the timing registers
  localparam logic [9:0] RST_RESET_LOW   = 10'd480;
  localparam logic [9:0] RST_PRES_DELAY  = 10'd70;
  localparam logic [9:0] RST_RESET_TAIL  = 10'd410;
  localparam logic [5:0] RST_SHORT_LOW   = 6'd6;
  localparam logic [6:0] RST_LONG_LOW    = 7'd60;
  localparam logic [6:0] RST_SLOT_LEN    = 7'd70;
  localparam logic [5:0] RST_READ_SAMPLE = 6'd15;

  // Bus sequencer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_RLOW  = 5'b00010,
    PH_RREL  = 5'b00100,
    PH_RTAIL = 5'b01000,
    PH_SLOT  = 5'b10000
  } phase_t;

  // Timing configuration as seen by the sequencer
  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_sample_delay;
    logic [9:0] reset_tail_time;
    logic [5:0] short_low_time;
    logic [6:0] long_low_time;
    logic [6:0] slot_length;
    logic [5:0] read_sample_delay;
  } cfg_t;

  // Fold one received bit into the running CRC
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic bit_in);
    logic [7:0] shifted;
    shifted = {1'b0, crc[7:1]};
    return (crc[0] ^ bit_in) ? (shifted ^ CRC_POLY) : shifted;
  endfunction

endpackage

@@ src/owb_cfg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owb_cfg
// Timing register file. Takes one write per cycle; indexes past the last
// register are accepted and dropped.
// ---------------------------------------------------------------------------
module owb_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [2:0]                         cfg_index,
  input  logic [owb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output owb_pkg::cfg_t                      cfg
);
  import owb_pkg::*;

  cfg_t cfg_r;

  // Always ready: a write completes in the cycle it is offered
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register writes, each field truncated to its own width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time        <= RST_RESET_LOW;
      cfg_r.presence_sample_delay <= RST_PRES_DELAY;
      cfg_r.reset_tail_time       <= RST_RESET_TAIL;
      cfg_r.short_low_time        <= RST_SHORT_LOW;
      cfg_r.long_low_time         <= RST_LONG_LOW;
      cfg_r.slot_length           <= RST_SLOT_LEN;
      cfg_r.read_sample_delay     <= RST_READ_SAMPLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESET_LOW:   cfg_r.reset_low_time        <= cfg_data[9:0];
        CFG_PRES_DELAY:  cfg_r.presence_sample_delay <= cfg_data[9:0];
        CFG_RESET_TAIL:  cfg_r.reset_tail_time       <= cfg_data[9:0];
        CFG_SHORT_LOW:   cfg_r.short_low_time        <= cfg_data[5:0];
        CFG_LONG_LOW:    cfg_r.long_low_time         <= cfg_data[6:0];
        CFG_SLOT_LEN:    cfg_r.slot_length           <= cfg_data[6:0];
        CFG_READ_SAMPLE: cfg_r.read_sample_delay     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/one_wire_bus_master_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// one_wire_bus_master_core
// One-wire bus master driven by microsecond ticks: reset with presence
// detect, byte write, byte read (LSB first) and a running Dallas CRC-8.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | op, tx_byte, line_level (one tick)
//   out_    | out | out_valid/out_stall| pull_low, busy, done, presence, rx, crc
//   cfg_    | in  | cfg_valid/cfg_ready| index 3b, data 10b
//
// One tick per clock cycle sustained while out_stall is low; a tick waits in
// the input register, then moves to the result register, where its result
// is valid.
// The sequencer update and the CRC fold are combinational, between the
// input register and the result register.
// in_stall rises only when a tick is held in the input register while the
// result register is full and stalled.
// rst_n is synchronous; it restores the default timings and idles the bus.
// ---------------------------------------------------------------------------
module one_wire_bus_master_core #(
  parameter int TIMER_WIDTH = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tick input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_op,
  input  logic [7:0]                     in_tx_byte,
  input  logic                           in_line_level,
  // per-tick result
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_pull_low,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic                           out_presence,
  output logic [7:0]                     out_rx_byte,
  output logic [7:0]                     out_crc_value,
  output logic                           out_crc_ok,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [owb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import owb_pkg::*;

  localparam int CW = 17;
  localparam logic [CW-1:0] TMAX = CW'((32'd1 << TIMER_WIDTH) - 32'd1);

  cfg_t cfg;

  owb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  logic       in_vld_r, in_vld_nxt;
  logic [2:0] op_r;
  logic [7:0] tx_r;
  logic       line_r;

  // Sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] tc_r, tc_nxt;
  logic [2:0]             bitpos_r, bitpos_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   reading_r, reading_nxt;
  logic [7:0]             crc_r, crc_nxt;
  logic                   pres_r, pres_nxt;
  logic [7:0]             rx_r, rx_nxt;

  // Result register
  logic out_vld_r, out_vld_nxt;
  logic pull_r, busy_r, done_r;
  logic pull_nxt, busy_nxt, done_nxt;

  logic accept, proc;

  // Handshake: a held tick moves on whenever the result register frees up
  assign proc     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !proc;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = accept ? 1'b1 : (proc ? 1'b0 : in_vld_r);
    out_vld_nxt = proc ? 1'b1 : (out_stall ? out_vld_r : 1'b0);
  end

  // One tick of the bus sequencer
  always_comb begin
    phase_t         ph;
    logic [CW-1:0]  tc;
    logic [CW-1:0]  len, lim, tc_inc;
    logic           adv;
    logic [6:0]     slot, sidx, low;
    phase_nxt   = phase_r;
    tc          = CW'(tc_r);
    bitpos_nxt  = bitpos_r;
    shift_nxt   = shift_r;
    reading_nxt = reading_r;
    crc_nxt     = crc_r;
    pres_nxt    = pres_r;
    rx_nxt      = rx_r;
    pull_nxt    = 1'b0;
    done_nxt    = 1'b0;
    busy_nxt    = 1'b0;
    ph          = phase_r;

    // Command decode while idle
    if (ph == PH_IDLE) begin
      tc         = '0;
      bitpos_nxt = '0;
      case (op_r)
        OP_RESET: begin
          crc_nxt = '0;
          ph      = PH_RLOW;
        end
        OP_WRITE: begin
          shift_nxt   = tx_r;
          reading_nxt = 1'b0;
          ph          = PH_SLOT;
        end
        OP_READ: begin
          shift_nxt   = '0;
          reading_nxt = 1'b1;
          ph          = PH_SLOT;
        end
        OP_CLR_CRC: begin
          crc_nxt  = '0;
          done_nxt = 1'b1;
        end
        default: ;
      endcase
    end

    // Duration of the current phase, clipped to the timer and at least one
    case (ph)
      PH_RLOW:  len = CW'(cfg.reset_low_time);
      PH_RREL:  len = CW'(cfg.presence_sample_delay);
      PH_RTAIL: len = CW'(cfg.reset_tail_time);
      PH_SLOT:  len = CW'(cfg.slot_length);
      default:  len = CW'(1);
    endcase
    lim    = (len > TMAX) ? TMAX : len;
    lim    = (lim == '0) ? CW'(1) : lim;
    tc_inc = (tc < TMAX) ? tc + CW'(1) : tc;
    adv    = (tc_inc >= lim);

    // Slot timing: low pulse width and read sample point
    slot = (cfg.slot_length == '0) ? 7'd1 : cfg.slot_length;
    sidx = (7'(cfg.read_sample_delay) < slot) ? 7'(cfg.read_sample_delay) : slot - 7'd1;
    if (reading_nxt || shift_nxt[0])
      low = 7'(cfg.short_low_time);
    else
      low = cfg.long_low_time;

    if (ph != PH_IDLE) busy_nxt = 1'b1;

    case (ph)
      PH_IDLE: ;
      PH_RLOW: begin
        pull_nxt = 1'b1;
        if (adv) ph = PH_RREL;
      end
      PH_RREL: begin
        if (adv) begin
          pres_nxt = !line_r;
          ph       = PH_RTAIL;
        end
      end
      PH_RTAIL: begin
        if (adv) begin
          ph       = PH_IDLE;
          done_nxt = 1'b1;
        end
      end
      PH_SLOT: begin
        pull_nxt = (tc < CW'(low));
        if (reading_nxt && (tc == CW'(sidx))) begin
          shift_nxt = {line_r, shift_nxt[7:1]};
          crc_nxt   = crc_fold(crc_nxt, line_r);
        end
        if (adv) begin
          if (!reading_nxt) shift_nxt = {1'b0, shift_nxt[7:1]};
          if (bitpos_nxt == 3'd7) begin
            bitpos_nxt = '0;
            if (reading_nxt) rx_nxt = shift_nxt;
            ph       = PH_IDLE;
            done_nxt = 1'b1;
          end else begin
            bitpos_nxt = bitpos_nxt + 3'd1;
          end
        end
      end
      default: begin
        ph       = PH_IDLE;
        busy_nxt = 1'b1;
      end
    endcase

    tc_nxt    = adv ? '0 : TIMER_WIDTH'(tc_inc);
    phase_nxt = ph;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_IDLE;
      tc_r      <= '0;
      bitpos_r  <= '0;
      shift_r   <= '0;
      reading_r <= 1'b0;
      crc_r     <= '0;
      pres_r    <= 1'b0;
      rx_r      <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (proc) begin
        phase_r   <= phase_nxt;
        tc_r      <= tc_nxt;
        bitpos_r  <= bitpos_nxt;
        shift_r   <= shift_nxt;
        reading_r <= reading_nxt;
        crc_r     <= crc_nxt;
        pres_r    <= pres_nxt;
        rx_r      <= rx_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      tx_r   <= in_tx_byte;
      line_r <= in_line_level;
    end
    if (proc) begin
      pull_r <= pull_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_pull_low  = pull_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_presence  = pres_r;
  assign out_rx_byte   = rx_r;
  assign out_crc_value = crc_r;
  assign out_crc_ok    = (crc_r == '0);

endmodule

@@ src/owb_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owb_checker
// Port-level checks for the one-wire bus master, bound to the top level.
// ---------------------------------------------------------------------------
`include "one_wire_bus_master_core_macros.svh"

module owb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_pull_low,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_rx_byte,
  input logic [7:0] out_crc_value,
  input logic       out_crc_ok
);

  // A stalled request keeps its result
  `OWB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_crc_value) && $stable(out_rx_byte) &&
                   $stable(out_pull_low) && $stable(out_done_res),
                   "stalled result changed")

  // crc_ok flag tracks the remainder
  `OWB_ASSERT(a_crc_ok, !out_valid || (out_crc_ok == (out_crc_value == 8'd0)),
              "crc_ok disagrees with crc_value")

  // The bus is only driven while a command runs
  `OWB_ASSERT(a_pull_busy, !(out_valid && out_pull_low) || out_busy_res, "bus driven while idle")

  // A one-tick completion is the CRC clear and leaves a zero remainder
  `OWB_ASSERT(a_clr_crc, !(out_valid && out_done_res && !out_busy_res) ||
              (out_crc_value == 8'd0), "CRC clear left nonzero remainder")

endmodule

bind one_wire_bus_master_core owb_checker u_owb_checker (.*);
